/* sv/fcit_pkg.sv */
`default_nettype none
package fcit_pkg;
  localparam int HW_TIMERS = 5;
  localparam int MAX_TIMERS = 8;
  localparam int DEF_NUM_TIMERS = 5;
  localparam int DEF_PCLK_HZ = 66000000;
  localparam int CTRL_W = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_W = 5;
  localparam logic [31:0] MIN_PERIOD = 32'd1000;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CNT0 = 3'd3;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [CTRL_W-1:0] ctrl;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  function automatic int start_pos(input int t);
    case (t)
      0: start_pos = 0;
      1: start_pos = 8;
      2: start_pos = 12;
      3: start_pos = 16;
      default: start_pos = 20;
    endcase
  endfunction

  function automatic int reload_pos(input int t);
    case (t)
      0: reload_pos = 3;
      1: reload_pos = 11;
      2: reload_pos = 15;
      3: reload_pos = 19;
      default: reload_pos = 22;
    endcase
  endfunction
endpackage
`default_nettype wire

/* sv/fcit_front.sv */
`default_nettype none
module fcit_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic [fcit_pkg::CTRL_W-1:0] in_control_word,
  output fcit_pkg::item_t                  q_data,
  output logic                             q_valid,
  input  wire logic                        q_pop
);
  fcit_pkg::item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{op: in_operation, ctrl: in_control_word};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
    end
  end
endmodule
`default_nettype wire

/* sv/fcit_back.sv */
`default_nettype none
module fcit_back #(
  parameter int NUM_TIMERS = fcit_pkg::DEF_NUM_TIMERS,
  parameter int PCLK_HZ = fcit_pkg::DEF_PCLK_HZ
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [fcit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcit_pkg::CFG_DATA_W-1:0] cfg_data,
  input  fcit_pkg::item_t                      q_data,
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [fcit_pkg::OUT_W-1:0]           out_timer_fired,
  output logic [fcit_pkg::OUT_W-1:0]           out_timers_running
);
  localparam int HW = fcit_pkg::HW_TIMERS;
  localparam int LIVE = (NUM_TIMERS < HW) ? NUM_TIMERS : HW;
  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [63:0] CLKC = 64'(PCLK_HZ);
  localparam logic [63:0] US_PER_S = 64'd1000000;

  logic [7:0] pre_lo_r, pre_hi_r;
  logic [19:0] div_r;
  logic [15:0] cbuf_r [HW];
  logic [fcit_pkg::CTRL_W-1:0] prev_r;
  logic [NUM_TIMERS-1:0] run_r, rel_r, fired_r;
  logic [31:0] el_r [NUM_TIMERS];
  fcit_pkg::state_t st_r, st_nxt;
  logic [TW-1:0] t_r;
  logic [28:0] prod_r;
  logic [15:0] cnt_sel;
  logic [8:0] pre_sel;
  logic [3:0] code_sel;
  logic [2:0] sh;
  logic [31:0] inc;
  logic fire;
  logic last_t;

  assign last_t = (32'(t_r) == 32'(NUM_TIMERS - 1));

  always_comb begin
    cnt_sel = 16'd1;
    pre_sel = 9'd1;
    code_sel = 4'd0;
    for (int i = 0; i < HW; i++) begin
      if (32'(t_r) == 32'(i)) begin
        cnt_sel = (cbuf_r[i] == 16'd0) ? 16'd1 : cbuf_r[i];
        pre_sel = {1'b0, (i <= 1) ? pre_lo_r : pre_hi_r} + 9'd1;
        code_sel = div_r[4*i +: 4];
      end
    end
    case (code_sel)
      4'd0: sh = 3'd1;
      4'd1: sh = 3'd2;
      4'd2: sh = 3'd3;
      4'd3: sh = 3'd4;
      default: sh = 3'd1;
    endcase
    inc = (el_r[t_r] == 32'hFFFFFFFF) ? el_r[t_r] : el_r[t_r] + 32'd1;
    fire = (inc >= fcit_pkg::MIN_PERIOD) &&
           ((64'(inc) + 64'd1) * CLKC > 64'(prod_r) * US_PER_S);
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    case (st_r)
      fcit_pkg::ST_IDLE: if (q_valid && !out_valid) begin
        if (q_data.op == fcit_pkg::OP_WRITE) st_nxt = fcit_pkg::ST_DONE;
        else st_nxt = fcit_pkg::ST_MUL1;
      end
      fcit_pkg::ST_MUL1: st_nxt = fcit_pkg::ST_MUL2;
      fcit_pkg::ST_MUL2: st_nxt = last_t ? fcit_pkg::ST_DONE : fcit_pkg::ST_MUL1;
      fcit_pkg::ST_DONE: begin
        q_pop = 1'b1;
        st_nxt = fcit_pkg::ST_IDLE;
      end
      default: st_nxt = fcit_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == fcit_pkg::ST_MUL1) begin
      prod_r <= 29'(cnt_sel * pre_sel) << sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_lo_r <= '0;
      pre_hi_r <= '0;
      div_r <= '0;
      for (int i = 0; i < HW; i++) cbuf_r[i] <= '0;
      prev_r <= '0;
      run_r <= '0;
      rel_r <= '0;
      fired_r <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) el_r[i] <= '0;
      st_r <= fcit_pkg::ST_IDLE;
      t_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          fcit_pkg::REG_PRE_LO: pre_lo_r <= cfg_data[7:0];
          fcit_pkg::REG_PRE_HI: pre_hi_r <= cfg_data[7:0];
          fcit_pkg::REG_DIV: div_r <= cfg_data;
          default: cbuf_r[3'(cfg_index - fcit_pkg::REG_CNT0)] <= cfg_data[15:0];
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st_r)
        fcit_pkg::ST_IDLE: begin
          t_r <= '0;
          fired_r <= '0;
          if (q_valid && !out_valid && q_data.op == fcit_pkg::OP_WRITE) begin
            for (int i = 0; i < LIVE; i++) begin
              rel_r[i] <= q_data.ctrl[fcit_pkg::reload_pos(i)];
              if (!prev_r[fcit_pkg::start_pos(i)] && q_data.ctrl[fcit_pkg::start_pos(i)]) begin
                el_r[i] <= '0;
                run_r[i] <= 1'b1;
              end else if (prev_r[fcit_pkg::start_pos(i)] &&
                           !q_data.ctrl[fcit_pkg::start_pos(i)]) begin
                run_r[i] <= 1'b0;
              end
            end
            prev_r <= q_data.ctrl;
          end
        end
        fcit_pkg::ST_MUL2: begin
          if (run_r[t_r]) begin
            if (fire) begin
              el_r[t_r] <= '0;
              fired_r[t_r] <= 1'b1;
              if (!rel_r[t_r]) run_r[t_r] <= 1'b0;
            end else begin
              el_r[t_r] <= inc;
            end
          end
          if (!last_t) t_r <= t_r + 1'b1;
        end
        fcit_pkg::ST_DONE: begin
          out_valid <= 1'b1;
          for (int i = 0; i < fcit_pkg::OUT_W; i++) begin
            out_timer_fired[i] <= (i < LIVE) ? fired_r[i] : 1'b0;
            out_timers_running[i] <= (i < LIVE) ? run_r[i] : 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/five_channel_interval_timer_top.sv */
// Five interval timers driven by an item stream.
// Input channel (in_valid/in_ready): in_operation 0 is a one-microsecond tick,
// 1 writes in_control_word (start and auto-reload bits per timer).
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
// prescalers, divider codes or count buffers; write only while idle.
// Result channel (out_valid/out_ready): one transfer per input item carrying
// out_timer_fired and out_timers_running.
// A two-entry queue separates acceptance from execution. With the back end idle
// a write goes from ST_IDLE to ST_DONE, which registers its result; a tick visits
// each timer in turn, through ST_MUL1 for the period product and ST_MUL2 for the
// compare, and then ST_DONE registers its result. The next item starts only after
// the result transfer, so the back end takes no new item before the last is through.
// Synchronous reset clears the config, state and timer registers, stops all timers, empties the queue.
// When the receiver stalls the result register holds, execution waits and
// the queue keeps taking items until full.
`default_nettype none
module five_channel_interval_timer_top #(
  parameter int NUM_TIMERS = fcit_pkg::DEF_NUM_TIMERS,
  parameter int PCLK_HZ = fcit_pkg::DEF_PCLK_HZ
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_operation,
  input  wire logic [fcit_pkg::CTRL_W-1:0]     in_control_word,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fcit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcit_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [fcit_pkg::OUT_W-1:0]           out_timer_fired,
  output logic [fcit_pkg::OUT_W-1:0]           out_timers_running
);
  fcit_pkg::item_t q_data;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;

  fcit_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_control_word,
    .q_data, .q_valid, .q_pop
  );

  fcit_back #(.NUM_TIMERS(NUM_TIMERS), .PCLK_HZ(PCLK_HZ)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .q_data, .q_valid, .q_pop,
    .out_valid, .out_ready, .out_timer_fired, .out_timers_running
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue pop while empty");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_timer_fired) &&
                                   $stable(out_timers_running)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
